// File: src/gef_pkg.sv
// gef_pkg: shared types and constants of the gradient edge filter
// used by gef_scan, gef_emit and the core top level; depends on nothing else
package gef_pkg;

  localparam int CFG_BITS   = 12;
  localparam int EDGE_BITS  = 17;
  localparam int COORD_BITS = 11;
  localparam int PIX_PORT_BITS = 16;
  localparam int CFG_ADDR_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FILTER_ENABLE = 2'd2;

  localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RESET = 12'd480;

  // per-pixel position flags, made by the scan counters
  typedef struct packed {
    logic has_out;   // a row above exists, so a result is due
    logic interior;  // filtered result (enable already folded in)
    logic last_row;  // pixel of the final row, also emits itself
    logic last_col;  // pixel ends its row
  } gef_flags_t;

endpackage

// File: src/gef_ram.sv
// gef_ram: generic single-write, single-read ram with registered read
// read-first: a read and write of one address return the old data; no dependencies
module gef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/gef_scan.sv
// gef_scan: row and column counters of the raster and the per-pixel flags
// depends on gef_pkg for the flag struct and config widths
module gef_scan import gef_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [CFG_BITS-1:0]           image_width,
  input  logic [CFG_BITS-1:0]           image_height,
  input  logic                          filter_enable,
  output logic [$clog2(MAX_WIDTH)-1:0]  col,
  output logic [$clog2(MAX_HEIGHT)-1:0] row,
  output gef_flags_t                    flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int MB = (WB > HB) ? WB : HB;
  localparam int SW = (MB > CFG_BITS) ? MB : CFG_BITS;

  logic [SW-1:0] w_cfg, h_cfg, w_eff, h_eff;
  logic [SW-1:0] c_ext, r_ext, ar_ext;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  always_comb begin
    w_cfg = SW'(image_width);
    h_cfg = SW'(image_height);
    if (w_cfg < SW'(2)) begin
      w_eff = SW'(2);
    end else if (w_cfg > SW'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg < SW'(2)) begin
      h_eff = SW'(2);
    end else if (h_cfg > SW'(MAX_HEIGHT)) begin
      h_eff = SW'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg;
    end
    c_ext  = SW'(col);
    r_ext  = SW'(row);
    ar_ext = r_ext - SW'(1);

    flags.has_out  = (row != '0);
    flags.last_col = (c_ext >= w_eff - SW'(1));
    flags.last_row = (r_ext >= h_eff - SW'(1));
    flags.interior = filter_enable && flags.has_out &&
                     (ar_ext >= SW'(1)) && (ar_ext <= h_eff - SW'(2)) &&
                     (col != '0) && (c_ext <= w_eff - SW'(2));

    // a column past a shrunken width still ends the row
    if (flags.last_col) begin
      col_next = '0;
      row_next = flags.last_row ? '0 : row + RW'(1);
    end else begin
      col_next = col + CW'(1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

// File: src/gef_emit.sv
// gef_emit: gradient arithmetic and the output register that sends one or two results
// depends on gef_pkg for the flag struct and output widths
module gef_emit import gef_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int CW         = 11,
  parameter int RW         = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s1_valid,
  input  gef_flags_t             s1_flags,
  input  logic [CW-1:0]          s1_col,
  input  logic [RW-1:0]          s1_row,
  input  logic [PIXEL_BITS-1:0]  s1_pix,
  input  logic [PIXEL_BITS-1:0]  centre,
  input  logic [PIXEL_BITS-1:0]  right,
  output logic                   s1_take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [EDGE_BITS-1:0]   edge_value,
  output logic [COORD_BITS-1:0]  out_row,
  output logic [COORD_BITS-1:0]  out_col,
  output logic                   frame_last
);

  logic                  busy;
  logic                  phase;      // second result (the pixel itself) pending
  logic                  has1;
  logic                  last_col;
  logic [PIXEL_BITS:0]   val0;
  logic [PIXEL_BITS-1:0] pix;
  logic [RW-1:0]         row_cur;
  logic [CW-1:0]         col_cur;

  logic [PIXEL_BITS-1:0] d_below, d_right;
  logic [PIXEL_BITS:0]   grad, val;
  logic                  out_fire, done, load_ok, load;
  logic [RW-1:0]         row_above;

  always_comb begin
    d_below = (s1_pix > centre) ? s1_pix - centre : centre - s1_pix;
    d_right = (right > centre) ? right - centre : centre - right;
    grad    = {1'b0, d_below} + {1'b0, d_right};
    val     = s1_flags.interior ? grad : {1'b0, centre};

    out_fire = busy && !out_stall;
    done     = out_fire && (phase || !has1);
    load_ok  = !busy || done;
    // a first-row pixel carries no result and just leaves stage one
    s1_take  = load_ok || !s1_flags.has_out;
    load     = s1_valid && s1_flags.has_out && load_ok;

    row_above  = row_cur - RW'(1);
    out_valid  = busy;
    out_col    = COORD_BITS'(col_cur);
    if (phase) begin
      edge_value = EDGE_BITS'(pix);
      out_row    = COORD_BITS'(row_cur);
      frame_last = last_col;
    end else begin
      edge_value = EDGE_BITS'(val0);
      out_row    = COORD_BITS'(row_above);
      frame_last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (done) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (out_fire && has1) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      has1     <= s1_flags.last_row;
      last_col <= s1_flags.last_col;
      val0     <= val;
      pix      <= s1_pix;
      row_cur  <= s1_row;
      col_cur  <= s1_col;
    end
  end

  a_phase_needs_pair: assert property (@(posedge clk) disable iff (rst)
    phase |-> busy && has1)
    else $error("second result pending on a single-result pixel");

  a_done_empties: assert property (@(posedge clk) disable iff (rst)
    done && !load |=> !busy)
    else $error("output register still full after its last result");

  a_first_then_second: assert property (@(posedge clk) disable iff (rst)
    out_fire && !phase && has1 |=> busy && phase)
    else $error("pixel of the final row lost its own result");

endmodule

// File: src/gradient_edge_filter_core.sv
// gradient_edge_filter_core: top level of the forward-difference edge filter
// depends on gef_pkg, gef_ram, gef_scan and gef_emit
//
// usage:
//   pixels enter in raster order on in_valid / in_stall / pixel_value; a request
//   is taken at a clock edge with in_valid high and in_stall low. results leave
//   on out_valid / out_stall with edge_value, out_row, out_col, frame_last.
//   a pixel of row r gives the result for (r-1, c); first-row pixels only fill
//   the line buffer, final-row pixels give the row-above result and then
//   themselves, frame_last marking the very last one.
//   a result passes the ram read stage (stage one), then the output register.
//   throughput: 1 pixel per clock while nothing stalls, set by the line
//   buffer's one write and read per cycle; on the final row each pixel gives
//   two results, and the output port sends one result per clock.
//   the line buffer is two copies of one ram so centre and right are read in
//   the same cycle.
//   reset: counters to zero, image_width 640, image_height 480, filter on;
//   the line buffer is not cleared (row 0 fills it before any read is used).
//   a stalled receiver holds the output register; stage one holds its ram data,
//   and in_stall rises once both are full. the user must write configuration
//   through cfg_write / cfg_addr / cfg_data only while idle; it is not enforced.
module gradient_edge_filter_core import gef_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]      cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIX_PORT_BITS-1:0] pixel_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [EDGE_BITS-1:0]     edge_value,
  output logic [COORD_BITS-1:0]    out_row,
  output logic [COORD_BITS-1:0]    out_col,
  output logic                     frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CFG_BITS-1:0]   image_width, image_height;
  logic                  filter_enable;

  logic                  accept;
  logic [CW-1:0]         col;
  logic [RW-1:0]         row;
  gef_flags_t            flags;
  logic [PIXEL_BITS-1:0] pix_in;
  logic [CW-1:0]         col_right;

  logic                  s1_valid;
  gef_flags_t            s1_flags;
  logic [CW-1:0]         s1_col;
  logic [RW-1:0]         s1_row;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [PIXEL_BITS-1:0] centre, right;
  logic                  s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RESET;
      image_height  <= IMAGE_HEIGHT_RESET;
      filter_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall  = s1_valid && !s1_take;
  assign accept    = in_valid && !in_stall;
  assign pix_in    = pixel_value[PIXEL_BITS-1:0];
  // wraps only on the last possible column, which is never interior
  assign col_right = col + CW'(1);

  gef_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .advance       (accept),
    .image_width   (image_width),
    .image_height  (image_height),
    .filter_enable (filter_enable),
    .col           (col),
    .row           (row),
    .flags         (flags)
  );

  // two copies of the line buffer: centre at col, right at col + 1
  gef_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_buf_centre (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pix_in),
    .re    (accept),
    .raddr (col),
    .rdata (centre)
  );

  gef_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_buf_right (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pix_in),
    .re    (accept),
    .raddr (col_right),
    .rdata (right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= flags;
      s1_col   <= col;
      s1_row   <= row;
      s1_pix   <= pix_in;
    end
  end

  gef_emit #(
    .PIXEL_BITS (PIXEL_BITS),
    .CW         (CW),
    .RW         (RW)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_flags   (s1_flags),
    .s1_col     (s1_col),
    .s1_row     (s1_row),
    .s1_pix     (s1_pix),
    .centre     (centre),
    .right      (right),
    .s1_take    (s1_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_value (edge_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("taken pixel did not reach stage one");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_take |=> s1_valid && $stable(s1_col) && $stable(centre))
    else $error("stage one lost its request while blocked");

endmodule
